// ===== rtl/core/ccns_pkg.sv =====
// Shared constants and codes for the cycle-count to nanosecond timebase.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ccns_pkg;

    // Default number of fraction bits in the fixed-point multiplier.
    localparam int unsigned FRACTION_SHIFT_DEF = 10;

    // Field widths.
    localparam int unsigned KHZ_W   = 24;
    localparam int unsigned COUNT_W = 64;
    localparam int unsigned TIME_W  = 64;

    // Nanoseconds per millisecond: the scale of a kHz frequency.
    localparam int unsigned NS_PER_MS = 1000000;

    // Reset frequency of the cycle counter in kHz.
    localparam logic [KHZ_W-1:0] KHZ_RESET = 24'd1000000;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register index, taken from the word address.
    localparam logic REG_COUNTER_KHZ = 1'b0;

    // Request codes.
    localparam logic OP_READ = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Width of the dividend (and quotient) for a given fraction shift.
    function automatic int unsigned num_width(input int unsigned shift);
        return 25 + shift;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ccns_div.sv =====
// Bit-serial restoring divider that derives the conversion multiplier
// from the counter frequency. Depends on ccns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccns_div #(
    parameter int unsigned FRAC_SHIFT = ccns_pkg::FRACTION_SHIFT_DEF,
    localparam int unsigned NUM_W = ccns_pkg::num_width(FRAC_SHIFT)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ccns_pkg::KHZ_W-1:0]   khz,
    output logic                              busy,
    output logic [NUM_W-1:0]                  mult
);

    localparam int unsigned KW    = ccns_pkg::KHZ_W;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [KW-1:0]    rem_reg, rem_next;
    logic [KW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [KW-1:0]    khz_safe;
    logic [KW:0]      shifted;
    logic [KW:0]      diff;
    logic             ge;

    // A zero frequency is treated as one.
    assign khz_safe = (khz == '0) ? KW'(1) : khz;

    // One quotient bit per cycle: shift in the next dividend bit, try a subtract.
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            // Dividend is the scaled constant plus half the divisor for rounding.
            quo_next  = (NUM_W'(ccns_pkg::NS_PER_MS) << FRAC_SHIFT)
                        + NUM_W'(khz_safe >> 1);
            rem_next  = '0;
            dvs_next  = khz_safe;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits KW bits.
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[KW-1:0] : shifted[KW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // The quotient register doubles as the multiplier; it resets to the
    // value for the reset frequency of 1000000 kHz.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= NUM_W'(1) << FRAC_SHIFT;
            rem_reg  <= '0;
            dvs_reg  <= ccns_pkg::KHZ_RESET;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign mult = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ccns_mul.sv =====
// Bit-serial shift-and-add multiplier: cycle count times multiplier,
// one count bit per cycle. Depends on ccns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccns_mul #(
    parameter int unsigned MULT_W = ccns_pkg::num_width(ccns_pkg::FRACTION_SHIFT_DEF),
    localparam int unsigned PROD_W = ccns_pkg::COUNT_W + MULT_W
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [ccns_pkg::COUNT_W-1:0]   count,
    input  wire logic [MULT_W-1:0]              mult,
    output logic                                done,
    output logic [PROD_W-1:0]                   product
);

    localparam int unsigned CW    = ccns_pkg::COUNT_W;
    localparam int unsigned CNT_W = $clog2(CW + 1);

    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [MULT_W:0]   sum;

    // Add the multiplier into the top when the low count bit is set.
    assign sum = {1'b0, acc_reg[PROD_W-1:CW]} + (acc_reg[0] ? {1'b0, mult} : '0);

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = {{MULT_W{1'b0}}, count};
            cnt_next = CNT_W'(CW);
        end
        else if (cnt_reg != '0)
        begin
            // The count bits shift out at the bottom as the product grows in.
            acc_next = {sum, acc_reg[CW-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cycle_count_to_nanoseconds_clock.sv =====
// Top level of the cycle-count to nanosecond timebase: APB register,
// request sequencer and time offset. Depends on ccns_pkg, ccns_div, ccns_mul.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one request per transfer:
//   op selects a read (returns time_ns) or a set (stores a new offset,
//   no result). cycle_count is the raw counter sample; new_time_ns is
//   the time to establish on a set.
// - Output channel (out_valid/out_ready) carries time_ns for each read.
// - A request passes through the bit-serial multiplier, which walks
//   all 64 count bits, and a read then goes to the output register; a
//   new request is accepted only once the previous one has finished.
// - Writing counter_khz starts the serial divider, which derives a
//   25 + FRACTION_SHIFT bit multiplier (35 bits by default); in_ready
//   stays low until the new multiplier is ready.
// - Reset sets counter_khz to 1000000, the multiplier to its matching
//   value and the time offset to zero; no divider run follows reset.
// - A result that the receiver does not take holds in the output
//   register; a following read waits at its last step until it drains,
//   while a following set still completes.
`timescale 1ns / 1ps
`default_nettype none

module cycle_count_to_nanoseconds_clock #(
    parameter int unsigned FRACTION_SHIFT = ccns_pkg::FRACTION_SHIFT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ccns_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ccns_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ccns_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // Request channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              op,
    input  wire logic [ccns_pkg::COUNT_W-1:0]      cycle_count,
    input  wire logic [ccns_pkg::TIME_W-1:0]       new_time_ns,
    // Result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [ccns_pkg::TIME_W-1:0]       time_ns
);

    localparam int unsigned MULT_W = ccns_pkg::num_width(FRACTION_SHIFT);
    localparam int unsigned PROD_W = ccns_pkg::COUNT_W + MULT_W;
    localparam int unsigned TW     = ccns_pkg::TIME_W;
    localparam int unsigned KW     = ccns_pkg::KHZ_W;
    localparam int unsigned DW     = ccns_pkg::APB_DATA_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [KW-1:0]     khz_reg;
    logic [TW-1:0]     offset_reg;
    logic              op_reg;
    logic [TW-1:0]     new_time_reg;
    logic              out_valid_reg;
    logic [TW-1:0]     time_ns_reg;

    logic              cfg_write;
    logic              khz_write;
    logic              div_busy;
    logic [MULT_W-1:0] mult;
    logic              in_xfer;
    logic              mul_done;
    logic [PROD_W-1:0] product;
    logic [TW-1:0]     conv_ns;
    logic              out_load;
    logic              set_done;

    // Register write decode; the word address selects the register.
    assign cfg_write = psel && penable && pwrite;
    assign khz_write = cfg_write && (paddr[2] == ccns_pkg::REG_COUNTER_KHZ);
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            ccns_pkg::REG_COUNTER_KHZ: prdata = DW'(khz_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            khz_reg <= ccns_pkg::KHZ_RESET;
        end
        else if (khz_write)
        begin
            khz_reg <= pwdata[KW-1:0];
        end
    end

    // Multiplier derivation.
    ccns_div #(
        .FRAC_SHIFT (FRACTION_SHIFT)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (khz_write),
        .khz   (pwdata[KW-1:0]),
        .busy  (div_busy),
        .mult  (mult)
    );

    // Request transfer and conversion.
    assign in_ready = (state_reg == ST_IDLE) && !div_busy;
    assign in_xfer  = in_valid && in_ready;

    ccns_mul #(
        .MULT_W (MULT_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xfer),
        .count   (cycle_count),
        .mult    (mult),
        .done    (mul_done),
        .product (product)
    );

    assign conv_ns  = product[FRACTION_SHIFT +: TW];
    assign set_done = (state_reg == ST_DONE) && (op_reg == ccns_pkg::OP_SET);
    assign out_load = (state_reg == ST_DONE) && (op_reg == ccns_pkg::OP_READ)
                      && (!out_valid_reg || out_ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (set_done || out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (set_done)
            begin
                offset_reg <= new_time_reg - conv_ns;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload and result data.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg       <= op;
            new_time_reg <= new_time_ns;
        end
        if (out_load)
        begin
            time_ns_reg <= conv_ns + offset_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign time_ns   = time_ns_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ccns_chk.sv =====
// Port-level checks for the cycle-count to nanosecond timebase, bound
// to the top level. Depends on ccns_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module ccns_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              psel,
    input wire logic                              penable,
    input wire logic                              pwrite,
    input wire logic [ccns_pkg::APB_ADDR_W-1:0]   paddr,
    input wire logic                              pready,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [ccns_pkg::TIME_W-1:0]       time_ns
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(time_ns))
        else $error("result changed while stalled");

    // One request at a time: the block is busy right after a transfer.
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // A frequency write keeps requests out while the multiplier is rebuilt.
    a_busy_after_khz: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
        && (paddr[2] == ccns_pkg::REG_COUNTER_KHZ) |=> !in_ready)
        else $error("request window open during divider run");

    // No result can appear the cycle after a request transfer.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind cycle_count_to_nanoseconds_clock ccns_chk u_ccns_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .time_ns   (time_ns)
);

`default_nettype wire
